### rtl/core/b64x_pkg.sv
package b64x_pkg;

  // Maximum number of characters that one input byte can produce.
  localparam int MAX_CHARS = 8;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);

  // Padding character of the Base64 alphabet.
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Configuration register indexes.
  localparam logic CFG_BYPASS   = 1'b0;
  localparam logic CFG_KEY_FOLD = 1'b1;

  typedef struct packed {
    logic [15:0] first_hold;
    logic [1:0]  first_count;
    logic [15:0] second_hold;
    logic [1:0]  second_count;
  } b64x_state_t;

  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [CNT_W-1:0]          count;
    logic                      last;
  } b64x_result_t;

  // Map a 6-bit code to its Base64 character.
  function automatic logic [7:0] b64_char(input logic [5:0] code);
    logic [7:0] x;
    x = {2'b00, code};
    if (x < 8'd26) begin
      return 8'h41 + x;
    end else if (x < 8'd52) begin
      return 8'h61 + x - 8'd26;
    end else if (x < 8'd62) begin
      return 8'h30 + x - 8'd52;
    end else if (x == 8'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

  // Encode a 24-bit group holding k real bytes (1..3) into four characters,
  // the first character in the top byte. Characters past k are padding.
  function automatic logic [31:0] enc_group(input logic [23:0] v, input logic [1:0] k);
    logic [31:0] res;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      if (i > int'(k)) begin
        res[31-8*i -: 8] = PAD_CHAR;
      end else begin
        res[31-8*i -: 8] = b64_char(v[23-6*i -: 6]);
      end
    end
    return res;
  endfunction

endpackage

### rtl/core/b64x_byte_if.sv
interface b64x_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

### rtl/core/b64x_char_if.sv
interface b64x_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

### rtl/core/base64_xor_base64_obfuscator_unit.sv
// Double Base64 log obfuscator. Log bytes arrive one per transaction on in_ch,
// with in_last on the final byte; encoded characters leave one per transaction
// on out_ch, with out_last on the final character of the log. Each byte is
// Base64 encoded, each first-stage character is XORed with key_fold, and that
// stream is Base64 encoded again; on the final byte both stages flush with '='
// padding. With bypass set, each byte passes through unchanged as one character
// and the stage state is kept, so an interrupted encoded log resumes later.
// Timing: a byte is registered at the input, then the whole two-stage encoding
// for it is computed in one pass and loaded into an eight-character output
// buffer once the buffer can take it. A byte yields 0, 4 or 8 characters (1 in
// bypass), and the buffer shifts out one character per cycle while the port is
// ready. A new byte is taken every cycle as long as the buffer is empty or is
// handing over its last character, and a byte that yields no characters never
// waits on the buffer. Over a long log the output port sets the pace: about 1.8
// characters per input byte. Registers are written through cfg_we, cfg_index
// and cfg_wdata; the user must do so only while no transaction is in flight,
// which the block does not enforce. No clearing pass is needed after reset.
module base64_xor_base64_obfuscator_unit (
  input  logic              clk,
  input  logic              rst_n,
  b64x_byte_if.sink         in_ch,
  b64x_char_if.source       out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata
);

  // Configuration registers.
  logic       bypass_r;
  logic [7:0] key_fold_r;

  // Input register.
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Encoder state of both stages.
  b64x_pkg::b64x_state_t state_r;
  b64x_pkg::b64x_state_t state_nxt;

  // Output buffer: character 0 is the one on the port.
  logic [b64x_pkg::MAX_CHARS-1:0][7:0] chars_r;
  logic [b64x_pkg::CNT_W-1:0]          rem_r;
  logic                                grp_last_r;

  b64x_pkg::b64x_result_t res;

  logic out_fire;
  logic buf_free;
  logic load;
  logic in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r   <= 1'b0;
      key_fold_r <= 8'h00;
    end else if (cfg_we) begin
      case (cfg_index)
        b64x_pkg::CFG_BYPASS:   bypass_r   <= cfg_wdata[0];
        b64x_pkg::CFG_KEY_FOLD: key_fold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  b64x_step u_step (
    .bypass   (bypass_r),
    .key_fold (key_fold_r),
    .in_byte  (in_byte_r),
    .in_last  (in_last_r),
    .st       (state_r),
    .st_nxt   (state_nxt),
    .res      (res)
  );

  assign out_fire = out_ch.valid && out_ch.ready;

  // The buffer can take a new group when it is empty or its final character
  // leaves in this cycle.
  assign buf_free = (rem_r == '0) ||
                    ((rem_r == b64x_pkg::CNT_W'(1)) && out_ch.ready);

  // A byte that produces no characters only updates the state.
  assign load     = in_vld_r && ((res.count == '0) || buf_free);
  assign in_ready = !in_vld_r || load;

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      in_byte_r <= in_ch.in_byte;
      in_last_r <= in_ch.in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (load) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r      <= '0;
      grp_last_r <= 1'b0;
    end else if (load && (res.count != '0)) begin
      rem_r      <= res.count;
      grp_last_r <= res.last;
    end else if (out_fire) begin
      rem_r <= rem_r - b64x_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && (res.count != '0)) begin
      chars_r <= res.chars;
    end else if (out_fire) begin
      for (int i = 0; i < b64x_pkg::MAX_CHARS - 1; i++) begin
        chars_r[i] <= chars_r[i+1];
      end
    end
  end

  assign out_ch.valid    = (rem_r != '0);
  assign out_ch.out_char = chars_r[0];
  assign out_ch.out_last = grp_last_r && (rem_r == b64x_pkg::CNT_W'(1));

  // The buffer never holds more characters than one byte can produce.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= b64x_pkg::CNT_W'(b64x_pkg::MAX_CHARS))
    else $error("output buffer count out of range");

  // Stage counts never reach a full group while held.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.first_count != 2'd3) && (state_r.second_count != 2'd3))
    else $error("stage holds three pending bytes");

  // After the final byte of an encoded log both stages are empty.
  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    load && !bypass_r && in_last_r |=>
      (state_r.first_count == 2'd0) && (state_r.second_count == 2'd0))
    else $error("stages not flushed after final byte");

  // A held byte is never dropped while the input side is stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> in_vld_r && $stable(in_byte_r) && $stable(in_last_r))
    else $error("input register lost a byte");

endmodule

### rtl/core/b64x_step.sv
// Computes, for one byte, the characters of both encoding stages and the
// stage state that follows.
module b64x_step (
  input  logic                 bypass,
  input  logic [7:0]           key_fold,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  b64x_pkg::b64x_state_t st,
  output b64x_pkg::b64x_state_t st_nxt,
  output b64x_pkg::b64x_result_t res
);

  logic [23:0] v1;
  logic [1:0]  k1;
  logic        emit1;
  logic [31:0] g1;
  logic [47:0] seq;
  logic [1:0]  k2;
  logic [31:0] grp0;
  logic [31:0] grp1;

  // Stage one: at most one group leaves per byte.
  always_comb begin
    case (st.first_count)
      2'd2: begin
        v1 = {st.first_hold, in_byte};
        k1 = 2'd3;
      end
      2'd1: begin
        v1 = {st.first_hold[7:0], in_byte, 8'h00};
        k1 = 2'd2;
      end
      default: begin
        v1 = {in_byte, 16'h0000};
        k1 = 2'd1;
      end
    endcase
  end

  assign emit1 = (st.first_count == 2'd2) || in_last;
  assign g1    = b64x_pkg::enc_group(v1, k1) ^ {4{key_fold}};

  // Stage two sees its pending bytes followed by the four stage-one characters.
  always_comb begin
    case (st.second_count)
      2'd0: begin
        seq = {g1, 16'h0000};
        k2  = 2'd1;
      end
      2'd1: begin
        seq = {st.second_hold[7:0], g1, 8'h00};
        k2  = 2'd2;
      end
      default: begin
        seq = {st.second_hold, g1};
        k2  = 2'd3;
      end
    endcase
  end

  assign grp0 = b64x_pkg::enc_group(seq[47:24], 2'd3);
  assign grp1 = b64x_pkg::enc_group(seq[23:0], k2);

  always_comb begin
    st_nxt    = st;
    res.chars = '0;
    res.count = '0;
    res.last  = 1'b0;
    if (bypass) begin
      res.chars[0] = in_byte;
      res.count    = b64x_pkg::CNT_W'(1);
      res.last     = in_last;
    end else if (emit1) begin
      st_nxt.first_hold  = '0;
      st_nxt.first_count = '0;
      for (int j = 0; j < 4; j++) begin
        res.chars[j] = grp0[31-8*j -: 8];
      end
      res.last = in_last;
      if ((k2 == 2'd3) || in_last) begin
        for (int j = 0; j < 4; j++) begin
          res.chars[j+4] = grp1[31-8*j -: 8];
        end
        res.count           = b64x_pkg::CNT_W'(8);
        st_nxt.second_hold  = '0;
        st_nxt.second_count = '0;
      end else begin
        res.count           = b64x_pkg::CNT_W'(4);
        st_nxt.second_hold  = (k2 == 2'd1) ? {8'h00, seq[23:16]} : seq[23:8];
        st_nxt.second_count = k2;
      end
    end else begin
      st_nxt.first_hold  = {st.first_hold[7:0], in_byte};
      st_nxt.first_count = st.first_count + 2'd1;
    end
  end

endmodule

### tb/base64_xor_base64_obfuscator_unit_tb.sv
`timescale 1ns / 1ps

module base64_xor_base64_obfuscator_unit_tb;

  // Cycles with no transaction on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 3000;
  // Cycles to let an accepted byte that yields no characters settle in the block.
  localparam int SETTLE_CYCLES = 4;
  localparam int SEG_ITEMS = 32;
  localparam int BYPASS_SEG_ITEMS = 9;

  // The Base64 alphabet, first symbol in the top byte.
  localparam logic [8*64-1:0] B64_SYMS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // How a row of the directed table is used. Model rows are checked against the
  // predictor, echo rows expect the byte back unchanged, typed rows carry their
  // eight characters written out by hand, config rows write a register.
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_MODEL,
    ROW_ECHO,
    ROW_TYPED
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data;   // byte, or register value for a write
    logic        flag;   // in_last, or register index for a write
    logic [63:0] chars;  // hand-written characters of a typed row
  } stim_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  localparam int DIR_ROWS = 27;
  localparam stim_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    // Fresh out of reset: key_fold is zero, so single-byte logs of the extreme
    // values have an output that can be worked out by hand.
    '{ROW_TYPED, 8'h00, 1'b1, "QUE9PQ=="},
    '{ROW_TYPED, 8'hFF, 1'b1, "L3c9PQ=="},
    // A full three-byte group, then a log that flushes two pending bytes.
    '{ROW_MODEL, 8'h4D, 1'b0, 64'h0},
    '{ROW_MODEL, 8'h61, 1'b0, 64'h0},
    '{ROW_MODEL, 8'h6E, 1'b1, 64'h0},
    '{ROW_MODEL, 8'h00, 1'b0, 64'h0},
    '{ROW_MODEL, 8'hFF, 1'b1, 64'h0},
    // All-ones key, then a log of one group plus a two-byte tail.
    '{ROW_CFG,   8'hFF, b64x_pkg::CFG_KEY_FOLD, 64'h0},
    '{ROW_MODEL, 8'hFF, 1'b0, 64'h0},
    '{ROW_MODEL, 8'h00, 1'b0, 64'h0},
    '{ROW_MODEL, 8'h80, 1'b0, 64'h0},
    '{ROW_MODEL, 8'h7F, 1'b0, 64'h0},
    '{ROW_MODEL, 8'h01, 1'b1, 64'h0},
    // A log left open, so both stages hold pending bytes across the bypass.
    '{ROW_MODEL, 8'h12, 1'b0, 64'h0},
    '{ROW_MODEL, 8'h34, 1'b0, 64'h0},
    '{ROW_MODEL, 8'h56, 1'b0, 64'h0},
    '{ROW_MODEL, 8'h78, 1'b0, 64'h0},
    // Bypass on; the value's upper bits are set and must be ignored.
    '{ROW_CFG,   8'hFF, b64x_pkg::CFG_BYPASS, 64'h0},
    '{ROW_ECHO,  8'h00, 1'b0, 64'h0},
    '{ROW_ECHO,  8'hFF, 1'b1, 64'h0},
    '{ROW_ECHO,  8'hA5, 1'b0, 64'h0},
    // Bit zero clear turns bypass off; the open log resumes and closes.
    '{ROW_CFG,   8'hFE, b64x_pkg::CFG_BYPASS, 64'h0},
    '{ROW_MODEL, 8'h9A, 1'b1, 64'h0},
    '{ROW_CFG,   8'h5A, b64x_pkg::CFG_KEY_FOLD, 64'h0},
    '{ROW_MODEL, 8'h3C, 1'b1, 64'h0},
    '{ROW_MODEL, 8'hC3, 1'b0, 64'h0},
    '{ROW_MODEL, 8'h0F, 1'b1, 64'h0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [7:0] cfg_wdata;

  b64x_byte_if in_ch ();
  b64x_char_if out_ch ();

  base64_xor_base64_obfuscator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the block's registers and of its two encoding stages.
  logic        sh_bypass = 1'b0;
  logic [7:0]  sh_key = 8'h00;
  logic [15:0] s1_hold = '0;
  logic [1:0]  s1_cnt = '0;
  logic [15:0] s2_hold = '0;
  logic [1:0]  s2_cnt = '0;

  // Characters produced by the byte being predicted, and the characters still
  // owed by the block, oldest first.
  logic [7:0] step_chars[$];
  enc_char_t  expected_chars[$];

  int tx_idle_pct = 31;
  int rx_idle_pct = 84;
  int err_count = 0;
  int bytes_sent = 0;
  int echo_bytes = 0;
  int logs_closed = 0;
  int chars_checked = 0;
  int stall_cycles = 0;

  function automatic logic [7:0] b64_sym(input logic [5:0] code);
    return B64_SYMS[8*(63-int'(code)) +: 8];
  endfunction

  // Character idx (0..3) of the Base64 quad for a group with nreal real bytes
  // left-aligned in grp; positions beyond the real data are padding.
  function automatic logic [7:0] quad_char(input logic [23:0] grp, input int nreal,
                                          input int idx);
    if (idx > nreal) begin
      return b64x_pkg::PAD_CHAR;
    end
    return b64_sym(grp[23-6*idx -: 6]);
  endfunction

  task automatic stage2_push(input logic [7:0] b);
    if (s2_cnt == 2'd2) begin
      for (int i = 0; i < 4; i++) begin
        step_chars.push_back(quad_char({s2_hold, b}, 3, i));
      end
      s2_hold = '0;
      s2_cnt = '0;
    end else begin
      s2_hold = {s2_hold[7:0], b};
      s2_cnt = s2_cnt + 2'd1;
    end
  endtask

  task automatic stage2_flush();
    logic [23:0] grp;
    if (s2_cnt != 2'd0) begin
      grp = (s2_cnt == 2'd1) ? {s2_hold[7:0], 16'h0} : {s2_hold, 8'h0};
      for (int i = 0; i < 4; i++) begin
        step_chars.push_back(quad_char(grp, int'(s2_cnt), i));
      end
      s2_hold = '0;
      s2_cnt = '0;
    end
  endtask

  // Every first-stage character, padding included, is folded with the key
  // before it enters the second stage.
  task automatic stage1_emit(input logic [23:0] grp, input int nreal);
    for (int i = 0; i < 4; i++) begin
      stage2_push(quad_char(grp, nreal, i) ^ sh_key);
    end
  endtask

  task automatic stage1_push(input logic [7:0] b);
    if (s1_cnt == 2'd2) begin
      stage1_emit({s1_hold, b}, 3);
      s1_hold = '0;
      s1_cnt = '0;
    end else begin
      s1_hold = {s1_hold[7:0], b};
      s1_cnt = s1_cnt + 2'd1;
    end
  endtask

  task automatic stage1_flush();
    if (s1_cnt != 2'd0) begin
      stage1_emit((s1_cnt == 2'd1) ? {s1_hold[7:0], 16'h0} : {s1_hold, 8'h0},
                  int'(s1_cnt));
      s1_hold = '0;
      s1_cnt = '0;
    end
  endtask

  // Work out the characters that one accepted byte causes. In both modes only
  // the final character of the step can carry the last marker, and it carries
  // exactly the byte's own marker.
  task automatic encode_step(input logic [7:0] b, input logic last);
    step_chars.delete();
    if (sh_bypass) begin
      step_chars.push_back(b);
    end else begin
      stage1_push(b);
      if (last) begin
        stage1_flush();
        stage2_flush();
      end
    end
  endtask

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Receiver: stall at random, and compare every accepted character with the
  // oldest one still owed. The handshake is sampled before ready is redriven.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          note_error($sformatf("unexpected char 0x%02h last %0b",
                               out_ch.out_char, out_ch.out_last));
        end else begin
          if (out_ch.out_char !== expected_chars[0].ch) begin
            note_error($sformatf("out_char expected 0x%02h got 0x%02h",
                                 expected_chars[0].ch, out_ch.out_char));
          end
          if (out_ch.out_last !== expected_chars[0].last) begin
            note_error($sformatf("out_last expected %0b got %0b (char 0x%02h)",
                                 expected_chars[0].last, out_ch.out_last,
                                 expected_chars[0].ch));
          end
          void'(expected_chars.pop_front());
        end
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one byte, idling first at the current sender rate, and record what it
  // must produce once the transaction completes. Valid stays high between
  // back-to-back bytes so it is never lowered and raised in one step.
  task automatic send_byte(input row_kind_t kind, input logic [7:0] b, input logic last,
                           input logic [63:0] typed);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);

    bytes_sent++;
    if (sh_bypass) begin
      echo_bytes++;
    end else if (last) begin
      logs_closed++;
    end
    // The predictor always runs so its stage state tracks the block, even when
    // the row supplies its own expected characters.
    encode_step(b, last);
    case (kind)
      ROW_TYPED: begin
        for (int k = 0; k < 8; k++) begin
          expected_chars.push_back('{typed[63-8*k -: 8], k == 7});
        end
      end
      ROW_ECHO: begin
        expected_chars.push_back('{b, last});
      end
      default: begin
        for (int k = 0; k < step_chars.size(); k++) begin
          expected_chars.push_back('{step_chars[k], last && (k == step_chars.size() - 1)});
        end
      end
    endcase
  endtask

  // Register writes happen only with the block drained: the sender goes quiet,
  // every owed character is collected, and a byte that produced nothing gets a
  // few cycles to clear the input register.
  task automatic write_reg(input logic idx, input logic [7:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == b64x_pkg::CFG_BYPASS) begin
      sh_bypass = value[0];
    end else begin
      sh_key = value;
    end
  endtask

  // Random log bytes lean toward the all-zeros and all-ones extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Fill a segment with logs: mostly short, some long, a few single-byte ones.
  // The segment end may cut a log, which a later encoded segment may carry on.
  task automatic send_logs(input int nitems);
    int left;
    int len;
    left = nitems;
    while (left > 0) begin
      case ($urandom_range(19))
        0: len = 1;
        1, 2, 3: len = $urandom_range(24, 10);
        default: len = $urandom_range(9, 1);
      endcase
      for (int k = 0; k < len && left > 0; k++) begin
        send_byte(ROW_MODEL, pick_byte(), k == len - 1, 64'h0);
        left--;
      end
    end
  endtask

  initial begin
    logic [7:0] key_val;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= b64x_pkg::CFG_BYPASS;
    cfg_wdata <= 8'h00;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.in_last <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, paced like the first random phase.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].kind == ROW_CFG) begin
        write_reg(DIR_TABLE[r].flag, DIR_TABLE[r].data);
      end else begin
        send_byte(DIR_TABLE[r].kind, DIR_TABLE[r].data, DIR_TABLE[r].flag,
                  DIR_TABLE[r].chars);
      end
    end

    // Random part: three pacing modes (slow receiver, slow sender, full speed).
    // Each mode runs segments with a zero key, an all-ones key, a random key,
    // and a short bypass stretch. Bypass writes carry random upper bits.
    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 31 : (p == 1) ? 84 : 0;
      rx_idle_pct = (p == 0) ? 84 : (p == 1) ? 31 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        key_val = (seg == 0) ? 8'h00 : (seg == 1) ? 8'hFF : 8'($urandom_range(255));
        write_reg(b64x_pkg::CFG_KEY_FOLD, key_val);
        write_reg(b64x_pkg::CFG_BYPASS, {7'($urandom_range(127)), seg == 3});
        if (seg == 3) begin
          for (int k = 0; k < BYPASS_SEG_ITEMS; k++) begin
            send_byte(ROW_MODEL, pick_byte(), 1'($urandom_range(1)), 64'h0);
          end
        end else begin
          send_logs(SEG_ITEMS);
        end
      end
    end

    // Drain: collect every owed character, then watch a little longer for
    // anything the block sends unasked.
    in_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d log bytes (%0d in bypass), closed %0d encoded logs, checked %0d chars.",
             bytes_sent, echo_bytes, logs_closed, chars_checked);
    $display("Keys zero, all-ones and random; bypass on and off; three pacing modes.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", err_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
